FILE: sv/pale_pkg.sv
package pale_pkg;

   // List geometry
   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   // Compare width covers both the 5-bit position field and the count, plus headroom for +1
   localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

   // Operation codes
   localparam logic [2:0] OP_INSERT  = 3'd0;
   localparam logic [2:0] OP_DELETE  = 3'd1;
   localparam logic [2:0] OP_SEARCH  = 3'd2;
   localparam logic [2:0] OP_REVERSE = 3'd3;
   localparam logic [2:0] OP_APPEND  = 3'd4;
   localparam logic [2:0] OP_SHOW    = 3'd5;

   // Status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_BADPOS   = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   // Commands from controller to datapath
   typedef enum logic [2:0] {
      CMD_NONE    = 3'd0,
      CMD_CAPTURE = 3'd1,
      CMD_SINGLE  = 3'd2,
      CMD_MATCH   = 3'd3,
      CMD_FOUND   = 3'd4,
      CMD_FLIP    = 3'd5,
      CMD_SHIFT   = 3'd6,
      CMD_SHOW    = 3'd7
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [2:0] operation;
      logic       out_free;
      logic       count_lt2;
      logic       count_zero;
      logic       shift_done;
      logic       show_last;
   } dp_status_type;

endpackage

FILE: sv/pale_req_if.sv
interface pale_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [4:0]  position;
   logic signed [31:0] value;

   modport source (output valid, output operation, output position, output value,
                   input ready);
   modport sink (input valid, input operation, input position, input value,
                 output ready);
endinterface

FILE: sv/pale_rsp_if.sv
interface pale_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [4:0]  found_position;
   logic signed [31:0] element_value;
   logic [4:0]  entry_count;
   logic        last_result;

   modport source (output valid, output status, output found_position,
                   output element_value, output entry_count, output last_result,
                   input ready);
   modport sink (input valid, input status, input found_position,
                 input element_value, input entry_count, input last_result,
                 output ready);
endinterface

FILE: sv/pale_ctrl.sv
module pale_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pale_pkg::dp_status_type dp_status,
   output pale_pkg::cmd_type      dp_cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_SRCH = 5'b00100,
      S_REV  = 5'b01000,
      S_SHOW = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and command decode
   always_comb begin
      state_in  = state_ff;
      dp_cmd    = pale_pkg::CMD_NONE;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd   = pale_pkg::CMD_CAPTURE;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (dp_status.operation)
               pale_pkg::OP_SEARCH: begin
                  dp_cmd   = pale_pkg::CMD_MATCH;
                  state_in = S_SRCH;
               end
               pale_pkg::OP_REVERSE: begin
                  if (!dp_status.count_lt2) begin
                     dp_cmd   = pale_pkg::CMD_FLIP;
                     state_in = S_REV;
                  end else if (dp_status.out_free) begin
                     dp_cmd   = pale_pkg::CMD_SINGLE;
                     state_in = S_IDLE;
                  end
               end
               pale_pkg::OP_SHOW: begin
                  if (!dp_status.count_zero) begin
                     state_in = S_SHOW;
                  end else if (dp_status.out_free) begin
                     dp_cmd   = pale_pkg::CMD_SINGLE;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  if (dp_status.out_free) begin
                     dp_cmd   = pale_pkg::CMD_SINGLE;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_SRCH: begin
            if (dp_status.out_free) begin
               dp_cmd   = pale_pkg::CMD_FOUND;
               state_in = S_IDLE;
            end
         end
         S_REV: begin
            if (!dp_status.shift_done) begin
               dp_cmd = pale_pkg::CMD_SHIFT;
            end else if (dp_status.out_free) begin
               // reverse reports ok through the single-result path
               dp_cmd   = pale_pkg::CMD_SINGLE;
               state_in = S_IDLE;
            end
         end
         S_SHOW: begin
            if (dp_status.out_free) begin
               dp_cmd = pale_pkg::CMD_SHOW;
               if (dp_status.show_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/pale_datapath.sv
module pale_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  pale_pkg::cmd_type       dp_cmd,
   output pale_pkg::dp_status_type dp_status,
   input  logic [2:0]              req_operation,
   input  logic [4:0]              req_position,
   input  logic signed [31:0]      req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_status,
   output logic [4:0]              rsp_found_position,
   output logic signed [31:0]      rsp_element_value,
   output logic [4:0]              rsp_entry_count,
   output logic                    rsp_last_result
);

   localparam int DEPTH = pale_pkg::DEPTH;
   localparam int CNT_W = pale_pkg::CNT_W;
   localparam int IDX_W = pale_pkg::IDX_W;
   localparam int CMP_W = pale_pkg::CMP_W;

   // List storage and working registers
   logic [31:0]        entry_ff [DEPTH];
   logic [31:0]        entry_in [DEPTH];
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [2:0]         op_ff;
   logic [4:0]         pos_ff;
   logic signed [31:0] val_ff;
   logic [DEPTH-1:0]   match_ff;
   logic [CNT_W-1:0]   shift_ff;
   logic [IDX_W-1:0]   idx_ff;

   // Output holding register
   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff;
   logic [4:0]         rsp_found_ff;
   logic signed [31:0] rsp_elem_ff;
   logic [4:0]         rsp_count_ff;
   logic               rsp_last_ff;

   logic               rsp_load;
   logic [2:0]         status_in;
   logic [4:0]         found_in;
   logic [31:0]        elem_in;

   // Single-result operation decode
   logic [CMP_W-1:0]   pos_w;
   logic [CMP_W-1:0]   cnt_w;
   logic               full;
   logic               ins_en;
   logic               del_en;
   logic [CMP_W-1:0]   ins_idx;
   logic [CMP_W-1:0]   del_idx;
   logic [2:0]         single_status;

   // Search encode
   logic               hit;
   logic [CNT_W-1:0]   hit_pos;

   logic               out_free;
   logic               show_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign show_last = ((CNT_W'(idx_ff) + 1'b1) == count_ff);

   assign dp_status.operation  = op_ff;
   assign dp_status.out_free   = out_free;
   assign dp_status.count_lt2  = (count_ff < CNT_W'(2));
   assign dp_status.count_zero = (count_ff == '0);
   assign dp_status.shift_done = (shift_ff == '0);
   assign dp_status.show_last  = show_last;

   // Status and edit enables for one-result operations
   always_comb begin
      pos_w         = CMP_W'(pos_ff);
      cnt_w         = CMP_W'(count_ff);
      full          = (count_ff == CNT_W'(DEPTH));
      ins_en        = 1'b0;
      del_en        = 1'b0;
      ins_idx       = pos_w - 1'b1;
      del_idx       = pos_w - 1'b1;
      single_status = pale_pkg::ST_OK;
      case (op_ff)
         pale_pkg::OP_INSERT: begin
            if (full) begin
               single_status = pale_pkg::ST_FULL;
            end else if (pos_w == '0 || pos_w > cnt_w + 1'b1) begin
               single_status = pale_pkg::ST_BADPOS;
            end else begin
               ins_en = 1'b1;
            end
         end
         pale_pkg::OP_DELETE: begin
            if (count_ff == '0) begin
               single_status = pale_pkg::ST_EMPTY;
            end else if (pos_w == '0 || pos_w > cnt_w) begin
               single_status = pale_pkg::ST_BADPOS;
            end else begin
               del_en = 1'b1;
            end
         end
         pale_pkg::OP_APPEND: begin
            ins_idx = cnt_w;
            if (full) begin
               single_status = pale_pkg::ST_FULL;
            end else begin
               ins_en = 1'b1;
            end
         end
         pale_pkg::OP_SHOW: begin
            // reaches here only for an empty list
            single_status = pale_pkg::ST_EMPTY;
         end
         default: begin
            single_status = pale_pkg::ST_OK;
         end
      endcase
   end

   // First match, lowest position wins
   always_comb begin
      hit     = 1'b0;
      hit_pos = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit     = 1'b1;
            hit_pos = CNT_W'(i + 1);
         end
      end
   end

   // Entry array next value: insert, delete, flip and shift-left
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entry_in[i] = entry_ff[i];
      end
      case (dp_cmd)
         pale_pkg::CMD_SINGLE: begin
            if (ins_en) begin
               for (int i = 1; i < DEPTH; i++) begin
                  if (CMP_W'(i) > ins_idx) begin
                     entry_in[i] = entry_ff[i-1];
                  end
               end
               for (int i = 0; i < DEPTH; i++) begin
                  if (CMP_W'(i) == ins_idx) begin
                     entry_in[i] = val_ff;
                  end
               end
            end else if (del_en) begin
               for (int i = 0; i < DEPTH - 1; i++) begin
                  if (CMP_W'(i) >= del_idx) begin
                     entry_in[i] = entry_ff[i+1];
                  end
               end
            end
         end
         pale_pkg::CMD_FLIP: begin
            // full-width mirror; the live entries then sit at the tail
            for (int i = 0; i < DEPTH; i++) begin
               entry_in[i] = entry_ff[DEPTH-1-i];
            end
         end
         pale_pkg::CMD_SHIFT: begin
            for (int i = 0; i < DEPTH - 1; i++) begin
               entry_in[i] = entry_ff[i+1];
            end
         end
         default: begin
         end
      endcase
   end

   // Count next value
   always_comb begin
      count_in = count_ff;
      if (dp_cmd == pale_pkg::CMD_SINGLE) begin
         if (ins_en) begin
            count_in = count_ff + 1'b1;
         end else if (del_en) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   // Result payload select
   always_comb begin
      rsp_load  = 1'b0;
      status_in = pale_pkg::ST_OK;
      found_in  = '0;
      elem_in   = '0;
      case (dp_cmd)
         pale_pkg::CMD_SINGLE: begin
            rsp_load  = 1'b1;
            status_in = single_status;
         end
         pale_pkg::CMD_FOUND: begin
            rsp_load  = 1'b1;
            status_in = hit ? pale_pkg::ST_OK : pale_pkg::ST_NOTFOUND;
            found_in  = 5'(hit_pos);
         end
         pale_pkg::CMD_SHOW: begin
            rsp_load = 1'b1;
            elem_in  = entry_ff[idx_ff];
         end
         default: begin
         end
      endcase
   end

   // Storage and working registers (payload, no reset)
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         entry_ff[i] <= entry_in[i];
      end
      case (dp_cmd)
         pale_pkg::CMD_CAPTURE: begin
            op_ff  <= req_operation;
            pos_ff <= req_position;
            val_ff <= req_value;
            idx_ff <= '0;
         end
         pale_pkg::CMD_MATCH: begin
            for (int i = 0; i < DEPTH; i++) begin
               match_ff[i] <= (entry_ff[i] == val_ff) && (CNT_W'(i) < count_ff);
            end
         end
         pale_pkg::CMD_FLIP: begin
            shift_ff <= CNT_W'(DEPTH) - count_ff;
         end
         pale_pkg::CMD_SHIFT: begin
            shift_ff <= shift_ff - 1'b1;
         end
         pale_pkg::CMD_SHOW: begin
            idx_ff <= idx_ff + 1'b1;
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_status_ff <= status_in;
         rsp_found_ff  <= found_in;
         rsp_elem_ff   <= elem_in;
         rsp_count_ff  <= 5'(count_in);
         rsp_last_ff   <= (dp_cmd != pale_pkg::CMD_SHOW) || show_last;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_ready);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_element_value  = rsp_elem_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_last_result    = rsp_last_ff;

`ifndef SYNTHESIS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result loaded over an untaken item");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd == pale_pkg::CMD_SINGLE && ins_en)
      |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("insert did not grow the list");

   a_show_in_range: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd == pale_pkg::CMD_SHOW) |-> (CNT_W'(idx_ff) < count_ff))
      else $error("show index past the tail");

   a_shift_only_reverse: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd == pale_pkg::CMD_SHIFT) |-> (op_ff == pale_pkg::OP_REVERSE && !rsp_load))
      else $error("shift outside a reverse");
`endif

endmodule

FILE: sv/positional_array_list_engine_unit.sv
// Ordered list of up to pale_pkg::DEPTH signed 32-bit entries held in a register
// array, with insert/delete/search/reverse/append/show by 1-based position. One
// item is worked at a time; results leave through an output register, so the
// next item is taken while the last result is still waiting. Insert, delete,
// append, unused codes, reverse of fewer than two entries and show of an empty
// list give one result; search registers a parallel compare, then encodes the
// first match; reverse mirrors the array whole and then shifts it toward the
// head one place a cycle; show emits one entry per cycle while the result side
// is ready.
module positional_array_list_engine_unit (
   input  logic       clock,
   input  logic       reset,
   pale_req_if.sink   req_chan,
   pale_rsp_if.source rsp_chan
);

   pale_pkg::cmd_type       dp_cmd;
   pale_pkg::dp_status_type dp_status;
   logic                    req_ready;

   pale_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   pale_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .dp_cmd             (dp_cmd),
      .dp_status          (dp_status),
      .req_operation      (req_chan.operation),
      .req_position       (req_chan.position),
      .req_value          (req_chan.value),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_status         (rsp_chan.status),
      .rsp_found_position (rsp_chan.found_position),
      .rsp_element_value  (rsp_chan.element_value),
      .rsp_entry_count    (rsp_chan.entry_count),
      .rsp_last_result    (rsp_chan.last_result)
   );

   assign req_chan.ready = req_ready;

endmodule

FILE: tb/positional_array_list_checker.sv
`timescale 1ns / 1ps

module positional_array_list_checker (
   input  logic clock,
   input  logic reset,
   pale_req_if  req_mon,
   pale_rsp_if  rsp_mon,
   output int   fail_count,
   output int   results_due
);
   import pale_pkg::*;

   typedef struct {
      logic [2:0]         status;
      logic [4:0]         found_position;
      logic signed [31:0] element_value;
      logic [4:0]         entry_count;
      logic               last_result;
   } list_result_type;

   // shadow copy of the stored list, head at index 0
   logic signed [31:0] list_entries [$];
   list_result_type    expected_results [$];
   int                 fault_total = 0;

   // work out what one accepted request item does to the list and what it returns
   task automatic predict_list_op(input logic [2:0] op, input logic [4:0] pos,
                                  input logic signed [31:0] val);
      int                 n;
      int                 hit;
      logic signed [31:0] tmp;
      list_result_type    res;
      n = list_entries.size();
      res = '{ST_OK, 5'd0, 32'sd0, 5'd0, 1'b1};
      case (op)
         OP_INSERT: begin
            if (n >= DEPTH)
               res.status = ST_FULL;
            else if (pos == 0 || int'(pos) > n + 1)
               res.status = ST_BADPOS;
            else
               list_entries.insert(int'(pos) - 1, val);
         end
         OP_DELETE: begin
            if (n == 0)
               res.status = ST_EMPTY;
            else if (pos == 0 || int'(pos) > n)
               res.status = ST_BADPOS;
            else
               list_entries.delete(int'(pos) - 1);
         end
         OP_SEARCH: begin
            // scan from the tail so the lowest match wins
            hit = 0;
            for (int i = n - 1; i >= 0; i--)
               if (list_entries[i] == val) hit = i + 1;
            if (hit == 0)
               res.status = ST_NOTFOUND;
            else
               res.found_position = 5'(hit);
         end
         OP_REVERSE: begin
            for (int i = 0; i < n / 2; i++) begin
               tmp = list_entries[i];
               list_entries[i] = list_entries[n - 1 - i];
               list_entries[n - 1 - i] = tmp;
            end
         end
         OP_APPEND: begin
            if (n >= DEPTH)
               res.status = ST_FULL;
            else
               list_entries.push_back(val);
         end
         OP_SHOW: begin
            if (n == 0)
               res.status = ST_EMPTY;
            else begin
               // one result per stored entry, last flag on the tail entry
               for (int i = 0; i < n; i++)
                  expected_results.push_back('{ST_OK, 5'd0, list_entries[i], 5'(n),
                                               i == n - 1});
               return;
            end
         end
         default: ;
      endcase
      res.entry_count = 5'(list_entries.size());
      expected_results.push_back(res);
   endtask

   // compare one accepted result item with the oldest expectation
   task automatic check_result();
      list_result_type want;
      if (expected_results.size() == 0) begin
         fault_total++;
         if (fault_total <= 10)
            $display("list_check: unexpected result status %0d pos %0d value %0d count %0d last %0b",
                     rsp_mon.status, rsp_mon.found_position, rsp_mon.element_value,
                     rsp_mon.entry_count, rsp_mon.last_result);
         return;
      end
      want = expected_results.pop_front();
      if (rsp_mon.status !== want.status || rsp_mon.found_position !== want.found_position ||
          rsp_mon.element_value !== want.element_value ||
          rsp_mon.entry_count !== want.entry_count ||
          rsp_mon.last_result !== want.last_result) begin
         fault_total++;
         if (fault_total <= 10) begin
            $display("list_check: mismatch at %0t", $realtime);
            $display("  exp status %0d pos %0d value %0d count %0d last %0b",
                     want.status, want.found_position, want.element_value,
                     want.entry_count, want.last_result);
            $display("  got status %0d pos %0d value %0d count %0d last %0b",
                     rsp_mon.status, rsp_mon.found_position, rsp_mon.element_value,
                     rsp_mon.entry_count, rsp_mon.last_result);
         end
      end
   endtask

   // results are checked before the same edge's request is predicted
   always @(posedge clock) begin
      if (reset) begin
         list_entries.delete();
         expected_results.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1)
            check_result();
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            predict_list_op(req_mon.operation, req_mon.position, req_mon.value);
      end
      fail_count  <= fault_total;
      results_due <= expected_results.size();
   end

endmodule

FILE: tb/positional_array_list_engine_unit_test.sv
`timescale 1ns / 1ps

module positional_array_list_engine_unit_test;
   import pale_pkg::*;

   // codes the block ignores
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 310;
   localparam int DRAIN_CYCLES = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   fail_count;
   int   results_due;
   int   list_len = 0;
   int   item_count = 0;
   int   random_goal;
   bit   steady_flow = 1'b0;
   logic signed [31:0] value_pool [8];

   pale_req_if req_bus ();
   pale_rsp_if rsp_bus ();

   positional_array_list_engine_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   positional_array_list_checker list_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= steady_flow || ($urandom_range(99) >= 22);
      end
   end

   // drive one request item and hold it until accepted; valid stays up between
   // back-to-back items
   task automatic send_item(input logic [2:0] op, input logic [4:0] pos,
                            input logic signed [31:0] val);
      if (!steady_flow && $urandom_range(99) < 22) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.position  <= pos;
      req_bus.value     <= val;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      item_count++;
      // rough length tracking, only to aim positions
      case (op)
         OP_INSERT: if (list_len < DEPTH && pos >= 1 && pos <= list_len + 1) list_len++;
         OP_APPEND: if (list_len < DEPTH) list_len++;
         OP_DELETE: if (pos >= 1 && pos <= list_len) list_len--;
         default: ;
      endcase
   endtask

   // pool values make duplicates and search hits likely
   function automatic logic signed [31:0] pick_value();
      if ($urandom_range(99) < 45) return value_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   // grow to full, then poke at the full list
   task automatic fill_list();
      while (list_len < DEPTH) send_item(OP_APPEND, 5'($urandom), pick_value());
      send_item(OP_INSERT, 5'($urandom_range(1, DEPTH + 1)), pick_value());
      send_item(OP_INSERT, 5'd0, pick_value());
      send_item(OP_APPEND, 5'($urandom), pick_value());
      send_item(OP_SHOW, 5'($urandom), pick_value());
      send_item(OP_REVERSE, 5'($urandom), pick_value());
   endtask

   // shrink to empty, then delete once more
   task automatic drain_list();
      while (list_len > 0) send_item(OP_DELETE, 5'($urandom_range(1, list_len)), $urandom);
      send_item(OP_DELETE, 5'($urandom_range(1, 31)), $urandom);
   endtask

   task automatic random_item();
      logic [2:0] op;
      logic [4:0] pos;
      int         pick;
      pick = $urandom_range(99);
      if (pick < 20) op = OP_INSERT;
      else if (pick < 30) op = OP_APPEND;
      else if (pick < 54) op = OP_DELETE;
      else if (pick < 74) op = OP_SEARCH;
      else if (pick < 82) op = OP_REVERSE;
      else if (pick < 92) op = OP_SHOW;
      else op = pick[0] ? OP_SPARE_LO : OP_SPARE_HI;
      // mostly legal positions, some anywhere in the field
      pos = 5'($urandom_range(0, 31));
      if ($urandom_range(99) < 85) begin
         if (op == OP_INSERT && list_len < DEPTH)
            pos = 5'($urandom_range(1, list_len + 1));
         else if (op == OP_DELETE && list_len > 0)
            pos = 5'($urandom_range(1, list_len));
      end
      send_item(op, pos, pick_value());
   endtask

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_INSERT;
      req_bus.position  = 5'd0;
      req_bus.value     = 32'sd0;
      value_pool[0] = 32'sd0;
      value_pool[1] = -32'sd1;
      value_pool[2] = 32'sh7FFF_FFFF;
      value_pool[3] = 32'sh8000_0000;
      value_pool[4] = 32'sd1;
      for (int i = 5; i < 8; i++) value_pool[i] = $urandom;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty list corner cases
      send_item(OP_SHOW, 5'd0, 32'sd0);
      send_item(OP_DELETE, 5'd1, 32'sd0);
      send_item(OP_SEARCH, 5'd0, 32'sd0);
      send_item(OP_REVERSE, 5'd0, 32'sd0);
      send_item(OP_INSERT, 5'd0, 32'sd5);
      send_item(OP_INSERT, 5'd2, 32'sd5);
      // build a short list with extreme values
      send_item(OP_INSERT, 5'd1, 32'sh7FFF_FFFF);
      send_item(OP_REVERSE, 5'd31, 32'sd0);
      send_item(OP_APPEND, 5'd31, 32'sh8000_0000);
      send_item(OP_INSERT, 5'd2, -32'sd1);
      send_item(OP_INSERT, 5'd31, 32'sd7);
      send_item(OP_SEARCH, 5'd0, -32'sd1);
      send_item(OP_SEARCH, 5'd0, 32'sd12345);
      send_item(OP_DELETE, 5'd0, 32'sd0);
      send_item(OP_DELETE, 5'd31, 32'sd0);
      send_item(OP_DELETE, 5'd3, 32'sd0);
      send_item(OP_SHOW, 5'd0, 32'sd0);
      send_item(OP_SPARE_LO, 5'd31, -32'sd1);
      send_item(OP_SPARE_HI, 5'd0, 32'sd0);
      send_item(OP_REVERSE, 5'd0, 32'sd0);
      send_item(OP_SEARCH, 5'd0, 32'sh8000_0000);

      // random part: full and empty episodes mixed into random traffic
      random_goal = item_count + RANDOM_ITEMS;
      fill_list();
      drain_list();
      while (item_count < random_goal) begin
         steady_flow = (item_count >= random_goal - 180 && item_count < random_goal - 100);
         pick_episode: begin
            int roll;
            roll = $urandom_range(99);
            if (roll < 4) fill_list();
            else if (roll < 9) drain_list();
            else random_item();
         end
      end
      steady_flow = 1'b0;
      req_bus.valid <= 1'b0;

      // wait out every expected result, then a margin for strays
      do @(posedge clock); while (results_due != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
